// ===== src/tmc_pkg.sv =====
// Package for the dissolved-solids median window converter.
// Shared widths, constants, register indexes and controller/datapath interface types.
// No dependencies.
package tmc_pkg;

    // Defaults of the top level parameters
    localparam int DEF_WINDOW   = 30;
    localparam int DEF_ADC_BITS = 12;

    // Fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAP_W      = 16;
    localparam int TEMP_W     = 15;
    localparam int PPM_W      = 11;
    localparam int TICK_W     = 32;

    // Arithmetic widths
    localparam int Q_FRAC    = 20;
    localparam int DIV_W     = 40;
    localparam int DSR_W     = 16;
    localparam int X_W       = 22;
    localparam int ACC_W     = 64;
    localparam int DIV_STEPS = DIV_W;
    localparam int MUL_STEPS = X_W;
    localparam int CNT_W     = 7;

    // Conversion constants (cubic coefficients scaled by 100)
    localparam int VOLT_NUM  = 33;
    localparam int VOLT_DEN  = 10;
    localparam int COMP_NUM  = 5000;
    localparam int TEMP_OFS  = 2500;
    localparam int C3        = 6671;
    localparam int C2        = 12793;
    localparam int C1        = 42870;
    localparam int C0        = 1800;
    localparam int PPM_SCALE = 100;
    localparam int PPM_MAX   = 1400;
    localparam int CV_MAX    = (1 << X_W) - 1;

    // Reset values of the config registers
    localparam int RST_SAMPLE_GAP = 1;
    localparam int RST_REPORT_GAP = 100;
    localparam int RST_WATER_TEMP = 2300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_GAP = 2'd0,
        REG_REPORT_GAP = 2'd1,
        REG_WATER_TEMP = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_MED_STEP,
        OP_DIV_V,
        OP_DIV_C,
        OP_DIV_T,
        OP_DIV_STEP,
        OP_MUL1,
        OP_MUL2,
        OP_MUL_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic report_due;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/tmc_ctrl.sv =====
// Controller for the median window converter: sequences median search,
// divider and multiplier passes. Depends on tmc_pkg.
module tmc_ctrl #(
    parameter int WINDOW = tmc_pkg::DEF_WINDOW
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output tmc_pkg::dp_cmd_t cmd,
    input  tmc_pkg::dp_sts_t sts
);
    import tmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MED, S_LD_V, S_LD_C, S_LD_M1, S_LD_M2, S_LD_T, S_DIV, S_MUL, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath command
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_TICK;
                    if (sts.report_due) begin
                        state_next = S_MED;
                        cnt_next   = '0;
                    end
                end
            end
            S_MED: begin
                cmd.op   = OP_MED_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WINDOW - 1)) begin
                    state_next = S_LD_V;
                end
            end
            S_LD_V: begin
                cmd.op     = OP_DIV_V;
                ret_next   = S_LD_C;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_LD_C: begin
                cmd.op     = OP_DIV_C;
                ret_next   = S_LD_M1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_LD_M1: begin
                cmd.op     = OP_MUL1;
                ret_next   = S_LD_M2;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_LD_M2: begin
                cmd.op     = OP_MUL2;
                ret_next   = S_LD_T;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_LD_T: begin
                cmd.op     = OP_DIV_T;
                ret_next   = S_OUT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ret_reg;
                end
            end
            S_MUL: begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = ret_reg;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/tmc_datapath.sv =====
// Datapath for the median window converter: tick timers, sample ring, median
// search, shared divider and multiplier, output register. Depends on tmc_pkg.
module tmc_datapath #(
    parameter int WINDOW   = tmc_pkg::DEF_WINDOW,
    parameter int ADC_BITS = tmc_pkg::DEF_ADC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [ADC_BITS-1:0]               s_adc_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tmc_pkg::PPM_W-1:0]         m_tds_ppm,
    output logic [ADC_BITS-1:0]               m_median_code,
    input  tmc_pkg::dp_cmd_t                  cmd,
    output tmc_pkg::dp_sts_t                  sts
);
    import tmc_pkg::*;

    localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int K_LO = (WINDOW - 1) / 2;
    localparam int K_HI = WINDOW / 2;

    // Config registers
    logic [GAP_W-1:0]         sample_gap_reg;
    logic [GAP_W-1:0]         report_gap_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    // Timers and ring
    logic [TICK_W-1:0]   tick_reg, last_s_reg, last_r_reg;
    logic [ADC_BITS-1:0] ring_reg [WINDOW];
    logic [IW-1:0]       wr_idx_reg;

    // Median search
    logic [IW-1:0]       med_idx_reg;
    logic [ADC_BITS-1:0] lo_reg, hi_reg;

    // Divider, multiplier
    logic [DIV_W-1:0]        dq_reg;
    logic [DSR_W-1:0]        rem_reg, dsr_reg;
    logic [X_W-1:0]          x_reg, mplr_reg;
    logic signed [ACC_W-1:0] mcand_reg, prod_reg;
    logic                    nonpos_reg;

    // Output register
    logic                m_valid_reg;
    logic [PPM_W-1:0]    tds_reg;
    logic [ADC_BITS-1:0] med_out_reg;

    logic [TICK_W-1:0]       tick_inc;
    logic                    samp_hit, rep_hit;
    logic [ADC_BITS-1:0]     cand;
    logic [WINDOW-1:0]       lt_vec, le_vec;
    logic [CW-1:0]           lt_cnt, le_cnt;
    logic [ADC_BITS:0]       mid_sum;
    logic [ADC_BITS-1:0]     median;
    logic [DSR_W:0]          div_trial;
    logic signed [DSR_W:0]   den_s;
    logic [X_W-1:0]          x_sat;
    logic signed [ACC_W-1:0] prod_tz, acc3;
    logic [PPM_W-1:0]        ppm;

    // Truncate toward zero on a divide by 2^Q_FRAC
    function automatic logic signed [ACC_W-1:0] tz_q(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] q;
        q = p >>> Q_FRAC;
        if (p < 0 && p[Q_FRAC-1:0] != '0) begin
            q = q + 1;
        end
        return q;
    endfunction

    // Tick compare
    assign tick_inc = tick_reg + 1'b1;
    assign samp_hit = (tick_inc - last_s_reg) > TICK_W'(sample_gap_reg);
    assign rep_hit  = (tick_inc - last_r_reg) > TICK_W'(report_gap_reg);

    // Rank of the current candidate against the whole ring
    assign cand = ring_reg[med_idx_reg];
    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            lt_vec[j] = ring_reg[j] < cand;
            le_vec[j] = ring_reg[j] <= cand;
        end
    end
    assign lt_cnt  = CW'($countones(lt_vec));
    assign le_cnt  = CW'($countones(le_vec));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign median  = mid_sum[ADC_BITS:1];

    // Divider trial subtract, compensation divisor
    assign div_trial = {rem_reg, dq_reg[DIV_W-1]};
    assign den_s     = (DSR_W+1)'(temp_reg) + (DSR_W+1)'(TEMP_OFS);
    assign x_sat     = (dq_reg > DIV_W'(CV_MAX)) ? X_W'(CV_MAX) : dq_reg[X_W-1:0];
    assign prod_tz   = tz_q(prod_reg);
    assign acc3      = prod_tz - (ACC_W'(C0) << Q_FRAC);
    assign ppm       = nonpos_reg ? '0 :
                       (dq_reg > DIV_W'(PPM_MAX)) ? PPM_W'(PPM_MAX) : dq_reg[PPM_W-1:0];

    assign sts.report_due = rep_hit;
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_gap_reg <= GAP_W'(RST_SAMPLE_GAP);
            report_gap_reg <= GAP_W'(RST_REPORT_GAP);
            temp_reg       <= TEMP_W'(RST_WATER_TEMP);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_GAP: sample_gap_reg <= cfg_wdata;
                REG_REPORT_GAP: report_gap_reg <= cfg_wdata;
                REG_WATER_TEMP: temp_reg       <= cfg_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Timers and sample ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= '0;
            last_s_reg <= '0;
            last_r_reg <= '0;
            wr_idx_reg <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (cmd.op == OP_TICK) begin
            tick_reg <= tick_inc;
            if (samp_hit) begin
                last_s_reg           <= tick_inc;
                ring_reg[wr_idx_reg] <= s_adc_sample;
                wr_idx_reg <= (wr_idx_reg == IW'(WINDOW - 1)) ? '0 : wr_idx_reg + 1'b1;
            end
            if (rep_hit) begin
                last_r_reg <= tick_inc;
            end
        end
    end

    // Median search, divider and multiplier
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_TICK: begin
                med_idx_reg <= '0;
            end
            OP_MED_STEP: begin
                if (lt_cnt <= CW'(K_LO) && le_cnt > CW'(K_LO)) begin
                    lo_reg <= cand;
                end
                if (lt_cnt <= CW'(K_HI) && le_cnt > CW'(K_HI)) begin
                    hi_reg <= cand;
                end
                med_idx_reg <= med_idx_reg + 1'b1;
            end
            OP_DIV_V: begin
                dq_reg  <= (DIV_W'(median) * DIV_W'(VOLT_NUM)) << (Q_FRAC - ADC_BITS);
                rem_reg <= '0;
                dsr_reg <= DSR_W'(VOLT_DEN);
            end
            OP_DIV_C: begin
                dq_reg  <= DIV_W'(dq_reg[X_W-1:0]) * DIV_W'(COMP_NUM);
                rem_reg <= '0;
                dsr_reg <= (den_s < 1) ? DSR_W'(1) : den_s[DSR_W-1:0];
            end
            OP_DIV_T: begin
                nonpos_reg <= (acc3 <= 0);
                dq_reg     <= DIV_W'(acc3 >>> Q_FRAC);
                rem_reg    <= '0;
                dsr_reg    <= DSR_W'(PPM_SCALE);
            end
            OP_DIV_STEP: begin
                if (div_trial >= {1'b0, dsr_reg}) begin
                    rem_reg <= DSR_W'(div_trial - {1'b0, dsr_reg});
                    dq_reg  <= {dq_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_reg <= div_trial[DSR_W-1:0];
                    dq_reg  <= {dq_reg[DIV_W-2:0], 1'b0};
                end
            end
            OP_MUL1: begin
                x_reg     <= x_sat;
                mplr_reg  <= x_sat;
                mcand_reg <= ACC_W'(x_sat) * ACC_W'(C3) - (ACC_W'(C2) << Q_FRAC);
                prod_reg  <= '0;
            end
            OP_MUL2: begin
                mplr_reg  <= x_reg;
                mcand_reg <= prod_tz + (ACC_W'(C1) << Q_FRAC);
                prod_reg  <= '0;
            end
            OP_MUL_STEP: begin
                if (mplr_reg[0]) begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg <= mcand_reg <<< 1;
                mplr_reg  <= mplr_reg >> 1;
            end
            OP_OUT: begin
                tds_reg     <= ppm;
                med_out_reg <= median;
            end
            default: ;
        endcase
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tds_ppm     = tds_reg;
    assign m_median_code = med_out_reg;

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before taken");
    a_ppm_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (tds_reg <= PPM_W'(PPM_MAX)))
        else $error("ppm above clamp");
    a_ring_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_idx_reg <= IW'(WINDOW - 1))
        else $error("ring write index out of range");
`endif

endmodule

// ===== src/tds_median_window_converter_core.sv =====
// Top level of the dissolved-solids median window converter.
// Instantiates tmc_ctrl and tmc_datapath; depends on tmc_pkg.
//
// Each input word is one timer tick with the current converter code. A tick
// that does not fall due for a report leaves the controller idle, so such
// ticks can be accepted every cycle. A reporting tick starts a run of the
// controller: median search (one ring entry ranked against all others per
// cycle), three passes of the shared restoring divider and two passes of the
// shift-add multiplier, each after its own load step, and an output step. No
// tick is accepted until the run is over, and the output step waits while a
// finished word still waits in the output register.
// The result word sits in an output register, so the next tick is accepted
// while it waits to be taken.
module tds_median_window_converter_core #(
    parameter int WINDOW   = tmc_pkg::DEF_WINDOW,
    parameter int ADC_BITS = tmc_pkg::DEF_ADC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ADC_BITS-1:0]            s_adc_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tmc_pkg::PPM_W-1:0]      m_tds_ppm,
    output logic [ADC_BITS-1:0]            m_median_code
);
    import tmc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tmc_ctrl #(
        .WINDOW(WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tmc_datapath #(
        .WINDOW   (WINDOW),
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_adc_sample  (s_adc_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tds_ppm     (m_tds_ppm),
        .m_median_code (m_median_code),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== verif/tb_tds_median_window_converter_core.sv =====
// Testbench for tds_median_window_converter_core: ticks drive a median window model,
// every report word is compared with a local prediction of the fixed-point conversion.
// Depends on tmc_pkg and the RTL of the converter core.
module tb_tds_median_window_converter_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tmc_pkg::*;

    localparam int NWIN = DEF_WINDOW;
    localparam int ABITS = DEF_ADC_BITS;
    localparam int REPORT_CYCLES = NWIN + 200;

    typedef struct packed {
        logic [PPM_W-1:0] ppm;
        logic [ABITS-1:0] med;
    } report_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    cfg_reg_t cfg_index = REG_SAMPLE_GAP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [ABITS-1:0] s_adc_sample = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [PPM_W-1:0] m_tds_ppm;
    logic [ABITS-1:0] m_median_code;

    tds_median_window_converter_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_adc_sample(s_adc_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tds_ppm(m_tds_ppm), .m_median_code(m_median_code)
    );

    // Predictor state
    logic [GAP_W-1:0] pr_sample_gap;
    logic [GAP_W-1:0] pr_report_gap;
    logic signed [TEMP_W-1:0] pr_temp;
    logic [TICK_W-1:0] pr_ticks, pr_last_sample, pr_last_report;
    logic [ABITS-1:0] pr_ring [NWIN];
    int pr_widx;

    logic [ABITS-1:0] tick_queue [$];
    report_t report_queue [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [ABITS-1:0] ring_median();
        logic [ABITS-1:0] buf_s [NWIN];
        logic [ABITS-1:0] k;
        int j;
        buf_s = pr_ring;
        for (int i = 1; i < NWIN; i++) begin
            k = buf_s[i];
            j = i - 1;
            while (j >= 0 && buf_s[j] > k) begin
                buf_s[j+1] = buf_s[j];
                j--;
            end
            buf_s[j+1] = k;
        end
        if (NWIN % 2) return buf_s[(NWIN-1)/2];
        return (13'(buf_s[NWIN/2]) + 13'(buf_s[NWIN/2-1])) >> 1;
    endfunction

    function automatic logic [PPM_W-1:0] ppm_of(logic [ABITS-1:0] med);
        longint v, cv, den, x, acc, top;
        v = (longint'(med) * VOLT_NUM * (64'sd1 <<< Q_FRAC)) / (VOLT_DEN * (64'sd1 <<< ABITS));
        den = longint'(pr_temp) + TEMP_OFS;
        if (den < 1) den = 1;
        cv = (v * COMP_NUM) / den;
        if (cv > CV_MAX) cv = CV_MAX;
        x = cv;
        acc = C3 * x - C2 * (64'sd1 <<< Q_FRAC);
        acc = (acc * x) / (64'sd1 <<< Q_FRAC) + C1 * (64'sd1 <<< Q_FRAC);
        acc = (acc * x) / (64'sd1 <<< Q_FRAC);
        acc -= C0 * (64'sd1 <<< Q_FRAC);
        if (acc <= 0) return '0;
        top = acc / (PPM_SCALE * (64'sd1 <<< Q_FRAC));
        if (top > PPM_MAX) top = PPM_MAX;
        return top[PPM_W-1:0];
    endfunction

    // Advance the model by one accepted tick
    task automatic model_tick(logic [ABITS-1:0] code);
        logic [ABITS-1:0] med;
        pr_ticks = pr_ticks + 1;
        if (pr_ticks - pr_last_sample > TICK_W'(pr_sample_gap)) begin
            pr_last_sample = pr_ticks;
            pr_ring[pr_widx] = code;
            pr_widx = (pr_widx + 1) % NWIN;
        end
        if (pr_ticks - pr_last_report > TICK_W'(pr_report_gap)) begin
            pr_last_report = pr_ticks;
            med = ring_median();
            report_queue.push_back('{ppm: ppm_of(med), med: med});
        end
    endtask

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) model_tick(s_adc_sample);
            if (!s_valid || s_ready) begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_adc_sample <= tick_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Monitor and receiver stalls
    always @(posedge aclk) begin
        report_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (report_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected report ppm=%0d med=%0d",
                                 m_tds_ppm, m_median_code);
                end else begin
                    exp_r = report_queue.pop_front();
                    if (exp_r.ppm !== m_tds_ppm || exp_r.med !== m_median_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: report exp ppm=%0d med=%0d got ppm=%0d med=%0d",
                                     exp_r.ppm, exp_r.med, m_tds_ppm, m_median_code);
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SAMPLE_GAP: pr_sample_gap = val;
            REG_REPORT_GAP: pr_report_gap = val;
            REG_WATER_TEMP: pr_temp = val[TEMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || s_valid || report_queue.size() > 0) @(posedge aclk);
        repeat (REPORT_CYCLES) @(posedge aclk);
        while (report_queue.size() > 0) @(posedge aclk);
    endtask

    function automatic logic [ABITS-1:0] rand_code();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return ABITS'($urandom);
        endcase
    endfunction

    // Random phase: report gap mostly small so reports are frequent
    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) tick_queue.push_back(rand_code());
        drain();
    endtask

    initial begin
        pr_sample_gap = RST_SAMPLE_GAP;
        pr_report_gap = RST_REPORT_GAP;
        pr_temp = RST_WATER_TEMP;
        pr_ticks = '0;
        pr_last_sample = '0;
        pr_last_report = '0;
        pr_widx = 0;
        foreach (pr_ring[i]) pr_ring[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: three ticks under reset settings, which bring no report, then extremes of codes
        for (int i = 0; i < 3; i++) tick_queue.push_back('1);
        drain();
        write_reg(REG_REPORT_GAP, 16'd0);
        write_reg(REG_SAMPLE_GAP, 16'd0);
        tick_queue.push_back('0);
        tick_queue.push_back('1);
        tick_queue.push_back(12'h800);
        tick_queue.push_back(12'h555);
        tick_queue.push_back(12'haaa);
        drain();
        // Temperature at -2000, the low end of the random phases; the compensation divisor stays positive
        write_reg(REG_WATER_TEMP, 16'(-2000));
        for (int i = 0; i < 6; i++) tick_queue.push_back('1);
        drain();
        write_reg(REG_WATER_TEMP, 16'h4000);
        tick_queue.push_back(12'h001);
        tick_queue.push_back('1);
        drain();
        write_reg(REG_WATER_TEMP, 16'h3fff);
        tick_queue.push_back('1);
        tick_queue.push_back(12'h123);
        drain();
        write_reg(REG_WATER_TEMP, 16'd10000);
        for (int i = 0; i < 4; i++) tick_queue.push_back('1);
        drain();

        // Random phases over several settings and idling modes
        write_reg(REG_WATER_TEMP, 16'd2500);
        write_reg(REG_REPORT_GAP, 16'd2);
        random_phase(150, 0, 0);
        write_reg(REG_SAMPLE_GAP, 16'd3);
        write_reg(REG_REPORT_GAP, 16'd0);
        write_reg(REG_WATER_TEMP, 16'($urandom_range(12000) - 2000));
        random_phase(150, 57, 0);
        write_reg(REG_SAMPLE_GAP, 16'd0);
        write_reg(REG_REPORT_GAP, 16'd5);
        write_reg(REG_WATER_TEMP, 16'($urandom_range(12000) - 2000));
        random_phase(150, 0, 57);
        write_reg(REG_REPORT_GAP, 16'd1);
        random_phase(120, 10, 10);

        // Long receiver hold-off while ticks keep coming
        write_reg(REG_REPORT_GAP, 16'd0);
        hold_off = 3000;
        random_phase(60, 0, 0);

        // Widest gaps: no sample, no report within these ticks
        write_reg(REG_SAMPLE_GAP, 16'hffff);
        write_reg(REG_REPORT_GAP, 16'hffff);
        random_phase(40, 0, 0);
        write_reg(REG_REPORT_GAP, 16'd0);
        random_phase(10, 0, 0);

        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
